// File: rtl/assert_macros.svh
// Assertion macros for the key scan report builder RTL.
// Needs a signal named clock and a signal named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: rtl/ksdrb_pkg.sv
// Shared constants and types for the key scan debounce report builder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ksdrb_pkg;

   localparam int KEY_COUNT    = 128;
   localparam int REPORT_SLOTS = 6;
   localparam int SLOT_MAX     = 6;
   localparam int ADDR_W       = $clog2(KEY_COUNT);
   localparam int HIST_W       = 5;
   localparam int PHASE_W      = 2;
   localparam int ENTRY_W      = HIST_W + PHASE_W;
   localparam int SLOT_CNT_W   = 3;
   localparam int CHAR_W       = 3;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 64;

   localparam logic [HIST_W-1:0] HIST_FULL = 5'h1F;

   localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PH_PEND = 2'd1;
   localparam logic [PHASE_W-1:0] PH_DONE = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_SAT = 3'd7;

   localparam logic [7:0] HID_CTRL_L = 8'hE0;
   localparam logic [7:0] HID_GUI_L  = 8'hE3;
   localparam logic [7:0] HID_GUI_R  = 8'hE7;
   localparam logic [7:0] HID_F13    = 8'h68;
   localparam logic [7:0] HID_F14    = 8'h69;
   localparam logic [7:0] HID_F15    = 8'h6A;
   localparam logic [7:0] HID_F16    = 8'h6B;
   localparam logic [7:0] HID_F18    = 8'h6D;
   localparam logic [7:0] HID_F20    = 8'h6F;
   localparam logic [7:0] HID_SPACE  = 8'h2C;
   localparam logic [7:0] HID_BKSP   = 8'h2A;
   localparam logic [7:0] HID_S      = 8'h16;
   localparam logic [7:0] HID_SCRLK  = 8'h47;

   localparam logic [7:0] MOD_SHIFT_L = 8'h02;
   localparam logic [7:0] MOD_ALT_L   = 8'h04;
   localparam logic [7:0] MOD_GUI_L   = 8'h08;

   // key sample after the state lookup, handed to the report logic
   typedef struct packed {
      logic       vld;
      logic       act;
      logic       down;
      logic       pend;
      logic [7:0] code;
      logic       last;
   } key_event_type;

   // result item, modifier byte in the low bits
   typedef struct packed {
      logic                       game;
      logic [CHAR_W-1:0]          chars;
      logic                       pause;
      logic                       any;
      logic [SLOT_MAX-1:0][7:0]   slots;
      logic [7:0]                 mods;
   } report_type;

endpackage

`default_nettype wire

// File: rtl/ksdrb_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Read during write to the same address returns the old data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ksdrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/ksdrb_key_state.sv
// Per-key debounce state: history and press phase in RAM, read-modify-write.
// Depends on ksdrb_pkg and ksdrb_ram.
`timescale 1ns / 1ps
`default_nettype none

module ksdrb_key_state (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_take,
   input  wire logic [6:0]              key_index,
   input  wire logic                    pressed,
   input  wire logic [7:0]              key_code,
   input  wire logic                    last_of_scan,
   input  wire logic                    consume,
   output ksdrb_pkg::key_event_type     key_event
);
   import ksdrb_pkg::*;

   logic                 s1_vld_ff, s1_vld_in;
   logic                 s1_act_ff;
   logic [ADDR_W-1:0]    s1_idx_ff;
   logic                 s1_cur_ff;
   logic [7:0]           s1_code_ff;
   logic                 s1_last_ff;

   logic [KEY_COUNT-1:0] valid_ff, valid_in;
   logic                 fwd_vld_ff, fwd_vld_in;
   logic [ADDR_W-1:0]    fwd_addr_ff;
   logic [ENTRY_W-1:0]   fwd_data_ff;

   logic [ENTRY_W-1:0]   ram_rd_data;
   logic [ENTRY_W-1:0]   entry_old;
   logic [HIST_W-1:0]    hist_new;
   logic [PHASE_W-1:0]   phase_old, phase_mid, phase_new;
   logic                 down;
   logic                 wr_en;

   ksdrb_ram #(.WIDTH(ENTRY_W), .DEPTH(KEY_COUNT)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data ({phase_new, hist_new}),
      .rd_en   (in_take),
      .rd_addr (ADDR_W'(key_index)),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == s1_idx_ff)) begin
         entry_old = fwd_data_ff;
      end else if (valid_ff[s1_idx_ff]) begin
         entry_old = ram_rd_data;
      end else begin
         entry_old = '0;
      end
      phase_old = entry_old[ENTRY_W-1:HIST_W];
      hist_new  = {entry_old[HIST_W-2:0], s1_cur_ff};
      down      = s1_cur_ff && (hist_new == HIST_FULL);
      if (down) begin
         phase_mid = (phase_old == PH_IDLE) ? PH_PEND : phase_old;
      end else if (!s1_cur_ff) begin
         phase_mid = PH_IDLE;
      end else begin
         phase_mid = phase_old;
      end
      phase_new = (down && consume) ? PH_DONE : phase_mid;
      wr_en     = s1_vld_ff && s1_act_ff;
   end

   assign key_event = '{vld:  s1_vld_ff,
                        act:  s1_act_ff,
                        down: down,
                        pend: (phase_mid == PH_PEND),
                        code: s1_code_ff,
                        last: s1_last_ff};

   always_comb begin
      s1_vld_in  = in_take;
      fwd_vld_in = wr_en;
      valid_in   = valid_ff;
      if (wr_en) begin
         valid_in[s1_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         fwd_vld_ff <= fwd_vld_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         s1_act_ff  <= (int'(key_index) < KEY_COUNT) && (key_code != HID_F20);
         s1_idx_ff  <= ADDR_W'(key_index);
         s1_cur_ff  <= pressed;
         s1_code_ff <= key_code;
         s1_last_ff <= last_of_scan;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_idx_ff;
         fwd_data_ff <= {phase_new, hist_new};
      end
   end

endmodule

`default_nettype wire

// File: rtl/ksdrb_report.sv
// Per-scan report accumulation, macro key handling and game mode toggle.
// Depends on ksdrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksdrb_report (
   input  wire logic                clock,
   input  wire logic                reset,
   input  ksdrb_pkg::key_event_type key_event,
   output logic                     consume,
   output logic                     push,
   output ksdrb_pkg::report_type    result
);
   import ksdrb_pkg::*;

   logic [7:0]                mods_ff, mods_in, mods_n;
   logic [SLOT_MAX-1:0][7:0]  slots_ff, slots_in, slots_n;
   logic [SLOT_CNT_W-1:0]     cnt_ff, cnt_in, cnt_n;
   logic                      any_ff, any_in, any_n;
   logic                      pause_ff, pause_in, pause_n;
   logic [CHAR_W-1:0]         char_ff, char_in, char_n;
   logic                      game_ff, game_in;
   logic                      put;
   logic [7:0]                put_code;
   logic                      toggle;
   logic [7:0]                code;

   assign code = key_event.code;

   always_comb begin
      mods_n   = mods_ff;
      slots_n  = slots_ff;
      cnt_n    = cnt_ff;
      any_n    = any_ff;
      pause_n  = pause_ff;
      char_n   = char_ff;
      consume  = 1'b0;
      put      = 1'b0;
      put_code = code;
      if (key_event.vld && key_event.act && key_event.down) begin
         any_n = 1'b1;
         if ((code >= HID_CTRL_L) && (code <= HID_GUI_R)) begin
            if (!game_ff || ((code != HID_GUI_L) && (code != HID_GUI_R))) begin
               mods_n[code[2:0]] = 1'b1;
            end
         end else if (cnt_ff < SLOT_CNT_W'(REPORT_SLOTS)) begin
            priority if (code == HID_F13) begin
               mods_n   = mods_n | MOD_GUI_L;
               put      = 1'b1;
               put_code = HID_SPACE;
               consume  = key_event.pend;
            end else if ((code == HID_F14) || (code == HID_F18)) begin
               if (key_event.pend) begin
                  pause_n = 1'b1;
                  consume = 1'b1;
               end
            end else if (code == HID_F15) begin
               mods_n   = mods_n | MOD_GUI_L | MOD_SHIFT_L;
               put      = 1'b1;
               put_code = HID_S;
            end else if (code == HID_F16) begin
               put      = 1'b1;
               put_code = HID_SCRLK;
            end else begin
               put = 1'b1;
               if ((code != HID_SPACE) && (code != HID_BKSP) && key_event.pend) begin
                  if (char_ff != CHAR_SAT) begin
                     char_n = char_ff + 1'b1;
                  end
                  consume = 1'b1;
               end
            end
            if (put) begin
               for (int k = 0; k < SLOT_MAX; k++) begin
                  if (cnt_ff == SLOT_CNT_W'(k)) begin
                     slots_n[k] = put_code;
                  end
               end
               cnt_n = cnt_ff + 1'b1;
            end
         end
      end

      push   = key_event.vld && key_event.last;
      toggle = ((mods_n & MOD_ALT_L) != 8'h00) && (slots_n[0] == HID_BKSP);

      result.mods  = any_n ? mods_n : 8'h00;
      result.slots = any_n ? slots_n : '0;
      result.any   = any_n;
      result.pause = pause_n;
      result.chars = char_n;
      result.game  = game_ff ^ toggle;

      if (push) begin
         mods_in  = '0;
         slots_in = '0;
         cnt_in   = '0;
         any_in   = 1'b0;
         pause_in = 1'b0;
         char_in  = '0;
         game_in  = game_ff ^ toggle;
      end else begin
         mods_in  = mods_n;
         slots_in = slots_n;
         cnt_in   = cnt_n;
         any_in   = any_n;
         pause_in = pause_n;
         char_in  = char_n;
         game_in  = game_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff  <= '0;
         slots_ff <= '0;
         cnt_ff   <= '0;
         any_ff   <= 1'b0;
         pause_ff <= 1'b0;
         char_ff  <= '0;
         game_ff  <= 1'b0;
      end else begin
         mods_ff  <= mods_in;
         slots_ff <= slots_in;
         cnt_ff   <= cnt_in;
         any_ff   <= any_in;
         pause_ff <= pause_in;
         char_ff  <= char_in;
         game_ff  <= game_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ksdrb_rsp_queue.sv
// Two-entry result queue that decouples report output from the consumer.
// Depends on ksdrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksdrb_rsp_queue (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  ksdrb_pkg::report_type                   push_data,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_tvalid,
   output logic      [ksdrb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic      [1:0]                         count
);
   import ksdrb_pkg::*;

   report_type q_ff [2];
   logic       head_ff, head_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;
   logic       wr_sel;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = RSP_DATA_W'(q_ff[head_ff]);
   assign count      = cnt_ff;
   assign wr_sel     = head_ff ^ cnt_ff[0];

   always_comb begin
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
      head_in = head_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         head_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_sel] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/key_scan_debounce_report_builder.sv
// Channel  Dir  Width  Accepted when
// req_     in   16+1   req_tvalid & req_tready (tlast = last_of_scan)
// rsp_     out  64     rsp_tvalid & rsp_tready, one report per scan end
//
// One request per cycle. A request is looked up in the key state RAM in the
// cycle after it is taken and written back at the end of that cycle; a
// back-to-back request to the same key uses the forwarded entry. The report
// is queued as the scan's last request is looked up. Reset is synchronous and
// clears all key state at once through per-key valid flags. Requests stall
// only while the two-entry report queue holds results not yet taken.
// Top level; depends on ksdrb_pkg, ksdrb_key_state, ksdrb_report,
// ksdrb_rsp_queue and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module key_scan_debounce_report_builder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // key_index[6:0], pressed[7], key_code[15:8]
   input  wire logic [ksdrb_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // modifier_bits[7:0], key_slot_0..5[55:8], any_key[56], pause_request[57],
   // chars_typed[60:58], game_mode_flag[61], zero[63:62]
   output logic      [ksdrb_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ksdrb_pkg::*;

   key_event_type key_event;
   report_type    result;
   logic          consume;
   logic          push;
   logic          in_take;
   logic          rsp_pop;
   logic [1:0]    q_cnt;

   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign req_tready = (q_cnt + {1'b0, key_event.vld && key_event.last})
                       < (2'd2 + {1'b0, rsp_pop});
   assign in_take    = req_tvalid && req_tready;

   ksdrb_key_state u_key_state (
      .clock        (clock),
      .reset        (reset),
      .in_take      (in_take),
      .key_index    (req_tdata[6:0]),
      .pressed      (req_tdata[7]),
      .key_code     (req_tdata[15:8]),
      .last_of_scan (req_tlast),
      .consume      (consume),
      .key_event    (key_event)
   );

   ksdrb_report u_report (
      .clock     (clock),
      .reset     (reset),
      .key_event (key_event),
      .consume   (consume),
      .push      (push),
      .result    (result)
   );

   ksdrb_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .count      (q_cnt)
   );

   `ASSERT_NEVER(a_queue_overflow, push && (q_cnt == 2'd2) && !rsp_tready, "report queue overflow")
   `ASSERT_CLK(a_take_to_lookup, in_take |=> key_event.vld, "taken request not looked up")
   `ASSERT_NEVER(a_consume_idle, consume && !(key_event.vld && key_event.down), "consume without press")
   `ASSERT_CLK(a_push_on_last, push == (key_event.vld && key_event.last), "report push mismatch")

endmodule

`default_nettype wire

// File: tb/sv/tb_key_scan_debounce_report_builder.sv
// Self-checking testbench for key_scan_debounce_report_builder: directed and
// randomized key scans over the request stream, reports checked on rsp_.
// Depends on ksdrb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_key_scan_debounce_report_builder;
   import ksdrb_pkg::*;

   localparam logic [7:0] HID_A     = 8'h04;
   localparam logic [7:0] HID_ALT_L = 8'hE2;
   localparam logic [7:0] HID_F17   = 8'h6C;
   localparam int         SCAN_LEN  = 16;
   localparam int         ITEM_GOAL = 1100;

   // debounce and report predictor plus expected report queue
   class key_report_scoreboard;
      bit [HIST_W-1:0]  history[KEY_COUNT];
      bit [PHASE_W-1:0] phase[KEY_COUNT];
      bit [7:0]         mods;
      bit [7:0]         slots[SLOT_MAX];
      int unsigned      nslots;
      bit               any;
      bit               pause;
      bit [CHAR_W-1:0]  chars;
      bit               game;
      report_type       expected_reports[$];
      int               errors;

      function void clear_scan();
         mods = '0;
         foreach (slots[k]) slots[k] = '0;
         nslots = 0;
         any = 0;
         pause = 0;
         chars = '0;
      endfunction

      function void add_slot(bit [7:0] code);
         slots[nslots] = code;
         nslots++;
      endfunction

      function void apply_key_down(int idx, bit [7:0] code);
         any = 1;
         if (code >= HID_CTRL_L && code <= HID_GUI_R) begin
            if (!game || (code != HID_GUI_L && code != HID_GUI_R))
               mods |= 8'd1 << (code - HID_CTRL_L);
            return;
         end
         if (nslots >= REPORT_SLOTS) return;
         if (code == HID_F13) begin
            mods |= MOD_GUI_L;
            add_slot(HID_SPACE);
            if (phase[idx] == PH_PEND) phase[idx] = PH_DONE;
         end else if (code == HID_F14 || code == HID_F18) begin
            if (phase[idx] == PH_PEND) begin
               pause = 1;
               phase[idx] = PH_DONE;
            end
         end else if (code == HID_F15) begin
            mods |= MOD_GUI_L | MOD_SHIFT_L;
            add_slot(HID_S);
         end else if (code == HID_F16) begin
            add_slot(HID_SCRLK);
         end else begin
            add_slot(code);
            if (code != HID_SPACE && code != HID_BKSP && phase[idx] == PH_PEND) begin
               if (chars != CHAR_SAT) chars++;
               phase[idx] = PH_DONE;
            end
         end
      endfunction

      function void note_request(bit [6:0] idx, bit pr, bit [7:0] code, bit last);
         report_type rpt;
         if (idx < KEY_COUNT && code != HID_F20) begin
            history[idx] = {history[idx][HIST_W-2:0], pr};
            if (pr && history[idx] == HIST_FULL) begin
               if (phase[idx] == PH_IDLE) phase[idx] = PH_PEND;
               apply_key_down(idx, code);
            end else if (!pr) begin
               phase[idx] = PH_IDLE;
            end
         end
         if (!last) return;
         if ((mods & MOD_ALT_L) != 0 && slots[0] == HID_BKSP) game = ~game;
         rpt = '0;
         if (any) begin
            rpt.mods = mods;
            for (int k = 0; k < SLOT_MAX; k++) rpt.slots[k] = slots[k];
         end
         rpt.any   = any;
         rpt.pause = pause;
         rpt.chars = chars;
         rpt.game  = game;
         expected_reports.push_back(rpt);
         clear_scan();
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_report(logic [RSP_DATA_W-1:0] data);
         report_type got;
         report_type want;
         got = data[$bits(report_type)-1:0];
         if (expected_reports.size() == 0) begin
            $error("report 0x%h arrived with none expected", data);
            errors++;
            return;
         end
         want = expected_reports.pop_front();
         compare_field("modifier_bits", want.mods, got.mods);
         for (int k = 0; k < SLOT_MAX; k++)
            compare_field($sformatf("key_slot_%0d", k), want.slots[k], got.slots[k]);
         compare_field("any_key", want.any, got.any);
         compare_field("pause_request", want.pause, got.pause);
         compare_field("chars_typed", want.chars, got.chars);
         compare_field("game_mode_flag", want.game, got.game);
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   key_report_scoreboard scoreboard = new();

   int  sender_idle_pct;
   int  rsp_stall_pct;
   int  items;

   logic [6:0] scan_keys[SCAN_LEN];
   logic [7:0] scan_codes[SCAN_LEN];
   bit         held[SCAN_LEN];

   key_scan_debounce_report_builder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // report receiver with random backpressure
   initial begin
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) scoreboard.check_report(rsp_tdata);
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 15))
         0:       return HID_CTRL_L + 8'($urandom_range(0, 7));
         1:       return HID_F13;
         2:       return HID_F14;
         3:       return HID_F15;
         4:       return HID_F16;
         5:       return HID_F17;
         6:       return HID_F18;
         7:       return HID_F20;
         8:       return HID_SPACE;
         9:       return HID_BKSP;
         10:      return HID_S;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_request(input logic [6:0] idx, input logic pr,
                               input logic [7:0] code, input logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {code, pr, idx};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      scoreboard.note_request(idx, pr, code, last);
      items++;
   endtask

   task automatic run_scan();
      int  n;
      logic pr;
      if ($urandom_range(0, 9) == 0) begin
         // broken scan: random samples, random scan end
         n = $urandom_range(1, 12);
         repeat (n)
            send_request(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 1) ? pick_code() : 8'($urandom_range(0, 255)),
                         $urandom_range(0, 5) == 0);
      end else begin
         if ($urandom_range(0, 19) == 0) foreach (held[i]) held[i] = 0;
         foreach (held[i]) begin
            if (held[i]) begin
               if ($urandom_range(0, 9) == 0) held[i] = 0;
            end else if ($urandom_range(0, 11) == 0) begin
               held[i] = 1;
            end
         end
         for (int i = 0; i < SCAN_LEN; i++) begin
            pr = held[i];
            if ($urandom_range(0, 29) == 0) pr = ~pr;
            send_request(scan_keys[i], pr, scan_codes[i], i == SCAN_LEN - 1);
         end
      end
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tlast = 0;
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      items = 0;
      scoreboard.clear_scan();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, skipped code, debounce, first press, release
      send_request(7'd0, 0, 8'h00, 1);
      send_request(7'd127, 1, 8'hFF, 0);
      send_request(7'd127, 1, HID_F20, 0);
      send_request(7'd64, 1, HID_GUI_R, 1);
      repeat (6) send_request(7'd5, 1, HID_A, 1);
      send_request(7'd5, 0, HID_F20, 1);
      send_request(7'd5, 0, HID_A, 1);
      repeat (5) send_request(7'd9, 1, HID_F14, 0);
      send_request(7'd9, 1, HID_F14, 1);

      for (int i = 0; i < SCAN_LEN; i++) begin
         scan_keys[i] = 7'(i * 8 + $urandom_range(0, 7));
         held[i] = 0;
      end
      scan_codes[0] = HID_ALT_L;
      scan_codes[1] = HID_BKSP;

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 76; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 76; end
            default: begin sender_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         for (int i = 2; i < SCAN_LEN; i++) scan_codes[i] = pick_code();
         while (items < (p + 1) * ITEM_GOAL / 4) run_scan();
      end
      req_tvalid <= 0;
      req_tlast  <= 0;

      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (scoreboard.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
